// ----- rtl/wpdr_pkg.sv -----
package wpdr_pkg;

    localparam int COUNT_W    = 16;
    localparam int DELTA_W    = 17;
    localparam int DSUM_W     = 18;
    localparam int POS_W      = 32;
    localparam int ANGLE_W    = 32;
    localparam int MOD_W      = 17;
    localparam int DPP_W      = 24;
    localparam int YAW_W      = 32;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIST_W     = 42;
    localparam int CORDIC_W   = 34;
    localparam int TRIG_W     = 23;
    localparam int MUL_A_W    = 43;
    localparam int MUL_B_W    = 23;
    localparam int MUL_P_W    = 66;

    typedef logic [COUNT_W-1:0]        count_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [DSUM_W-1:0]  dsum_t;
    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic [ANGLE_W-1:0]        angle_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [CORDIC_W-1:0] cvec_t;

    localparam logic OP_TRACK    = 1'b0;
    localparam logic OP_SET_POSE = 1'b1;

    localparam logic [DIR_W-1:0] DIR_STAND = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BWD   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW     = 2'd2;

    localparam logic [MOD_W-1:0] MOD_MAX   = 17'h10000;
    localparam logic [MOD_W-1:0] MOD_RESET = 17'h10000;

    localparam cvec_t CORDIC_GAIN = 34'sh026DD3B6A;
    localparam cvec_t TRIG_ROUND  = 34'sd512;
    localparam logic [MUL_P_W-1:0] POS_ROUND = 66'h10000000;
    localparam angle_t QUARTER_TURN = 32'h40000000;
    localparam angle_t HALF_TURN    = 32'h80000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TURN,
        S_DIST,
        S_ANGLE,
        S_ROTATE,
        S_MULX,
        S_MULY,
        S_ADDY,
        S_DONE
    } core_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROTATE,
        C_ROUND
    } cordic_state_t;

    typedef struct packed {
        logic step;
        logic clear;
    } delta_ctl_t;

    // arctangent of 2^-i, full turn = 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/wpdr_if.sv -----
interface wpdr_cfg_if import wpdr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface wpdr_in_if import wpdr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    count_t           left_count;
    count_t           right_count;
    logic [DIR_W-1:0] direction;
    pos_t             start_x;
    pos_t             start_y;
    angle_t           start_heading;

    modport source (output valid, operation, left_count, right_count, direction,
                    start_x, start_y, start_heading, input ready);
    modport sink (input valid, operation, left_count, right_count, direction,
                  start_x, start_y, start_heading, output ready);
endinterface

interface wpdr_out_if import wpdr_pkg::*; ();
    logic   valid;
    logic   ready;
    pos_t   pos_x;
    pos_t   pos_y;
    angle_t heading;
    delta_t left_delta;
    delta_t right_delta;

    modport source (output valid, pos_x, pos_y, heading, left_delta, right_delta,
                    input ready);
    modport sink (input valid, pos_x, pos_y, heading, left_delta, right_delta,
                  output ready);
endinterface

// ----- rtl/wpdr_delta.sv -----
module wpdr_delta import wpdr_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  delta_ctl_t       ctl,
    input  count_t           cur,
    input  logic [DIR_W-1:0] dir,
    input  logic [MOD_W-1:0] modulus,
    output delta_t           delta
);

    localparam count_t CMASK = COUNT_W'((33'd1 << COUNT_BITS) - 33'd1);

    count_t             prev_count_reg;
    delta_t             prev_delta_reg;
    count_t             cur_m;
    logic [MOD_W-1:0]   mod_eff;
    logic [MOD_W-1:0]   wrap;
    logic [DSUM_W-1:0]  raw;
    logic [DSUM_W-1:0]  dir_raw;
    logic               has_history;
    logic               moving;

    always_comb
    begin
        cur_m   = cur & CMASK;
        mod_eff = (modulus > MOD_MAX) ? MOD_MAX : modulus;
        wrap    = (cur_m < prev_count_reg) ? mod_eff : '0;
        raw     = {2'b00, cur_m} - {2'b00, prev_count_reg} + {1'b0, wrap};
        dir_raw = (dir == DIR_BWD) ? (DSUM_W'(0) - raw) : raw;
        has_history = (prev_count_reg != '0) || (prev_delta_reg != '0);
        moving      = (dir == DIR_FWD) || (dir == DIR_BWD);
        delta   = (has_history && moving) ? delta_t'(dir_raw[DELTA_W-1:0]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
            prev_delta_reg <= '0;
        end
        else if (ctl.clear)
        begin
            prev_count_reg <= '0;
            prev_delta_reg <= '0;
        end
        else if (ctl.step)
        begin
            prev_count_reg <= cur_m;
            prev_delta_reg <= delta;
        end
    end

endmodule

// ----- rtl/wpdr_mul.sv -----
module wpdr_mul import wpdr_pkg::*; (
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] product
);

    logic signed [MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign product = product_reg;

endmodule

// ----- rtl/wpdr_cordic.sv -----
module wpdr_cordic import wpdr_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  angle_t angle,
    output logic   done,
    output trig_t  cos_q20,
    output trig_t  sin_q20
);

    localparam int IW = $clog2(STEPS);
    localparam logic [IW-1:0] LAST_STEP = IW'(STEPS - 1);

    cordic_state_t state_reg, state_next;
    logic [IW-1:0] step_reg, step_next;
    cvec_t         x_reg, x_next;
    cvec_t         y_reg, y_next;
    cvec_t         z_reg, z_next;
    logic          flip_reg, flip_next;
    logic          done_reg, done_next;
    trig_t         cos_reg, cos_next;
    trig_t         sin_reg, sin_next;

    angle_t        folded;
    angle_t        probe;
    cvec_t         x_sh, y_sh, atan_v;
    cvec_t         xc, yc, xr, yr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        done_next  = 1'b0;

        // fold into the right half plane, undo by negating both results
        probe  = angle + QUARTER_TURN;
        folded = probe[ANGLE_W-1] ? (angle + HALF_TURN) : angle;

        x_sh   = x_reg >>> step_reg;
        y_sh   = y_reg >>> step_reg;
        atan_v = cvec_t'({2'b00, atan_turn(5'(step_reg))});

        xc = flip_reg ? (-x_reg) : x_reg;
        yc = flip_reg ? (-y_reg) : y_reg;
        xr = xc + TRIG_ROUND;
        yr = yc + TRIG_ROUND;

        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    flip_next  = probe[ANGLE_W-1];
                    x_next     = CORDIC_GAIN;
                    y_next     = '0;
                    z_next     = cvec_t'({{(CORDIC_W-ANGLE_W){folded[ANGLE_W-1]}}, folded});
                    step_next  = '0;
                    state_next = C_ROTATE;
                end
            end
            C_ROTATE:
            begin
                if (!z_reg[CORDIC_W-1])
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_v;
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_v;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                cos_next   = trig_t'(xr[TRIG_W+9:10]);
                sin_next   = trig_t'(yr[TRIG_W+9:10]);
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign done    = done_reg;
    assign cos_q20 = cos_reg;
    assign sin_q20 = sin_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == C_IDLE)
        else $error("cordic started while busy");

    a_done_is_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("cordic done held longer than one cycle");

    a_round_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_ROUND |=> done_reg && state_reg == C_IDLE)
        else $error("cordic rounding did not finish");

endmodule

// ----- rtl/wheel_pulse_dead_reckoning_core.sv -----
// Wheel pulse dead reckoning for a differential-drive vehicle.
// counts: one request per odometry sample. operation selects a track update
//   (left/right counter readings and direction code) or a set-pose load
//   (start_x, start_y, start_heading). The block is ready only when idle.
// pose: one result per request with the updated position, heading and the
//   signed left/right pulse deltas of that request (zero for a set-pose).
// cfg: register writes (pulse modulus, distance per pulse, yaw gain), always
//   ready; write only while no request is in flight.
// A track request passes the turn and distance products, the iterative CORDIC
//   rotating one step per cycle, and the x and y products: four passes through
//   the single shared multiplier. A set-pose request loads the pose and goes
//   straight to the finish step. A new request is taken only after the last
//   one has left the sequencer.
// Reset clears the pose, the counter history and loads the register defaults.
// The result sits in an output register; the next request is accepted while
//   it waits, and a finished result holds the sequencer until pose is taken.
module wheel_pulse_dead_reckoning_core import wpdr_pkg::*; #(
    parameter int COUNT_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    wpdr_cfg_if.sink   cfg,
    wpdr_in_if.sink    counts,
    wpdr_out_if.source pose
);

    core_state_t state_reg, state_next;

    logic [MOD_W-1:0] modulus_reg;
    logic [DPP_W-1:0] dpp_reg;
    logic [YAW_W-1:0] yaw_reg;

    pos_t   x_reg, x_next;
    pos_t   y_reg, y_next;
    angle_t heading_reg, heading_next;
    angle_t mid_reg, mid_next;
    delta_t dl_reg, dl_next;
    delta_t dr_reg, dr_next;
    logic signed [DIST_W-1:0] dist_reg, dist_next;

    logic   out_valid_reg, out_valid_next;
    pos_t   out_x_reg, out_x_next;
    pos_t   out_y_reg, out_y_next;
    angle_t out_heading_reg, out_heading_next;
    delta_t out_dl_reg, out_dl_next;
    delta_t out_dr_reg, out_dr_next;

    logic       accept;
    logic       out_load;
    logic       cordic_start;
    logic       cordic_done;
    trig_t      cos_q20, sin_q20;
    delta_ctl_t dctl;
    delta_t     delta_l, delta_r;
    dsum_t      dsum, ddiff;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] product;
    logic [MUL_P_W-1:0]        pos_step;

    assign cfg.ready    = 1'b1;
    assign counts.ready = (state_reg == S_IDLE);
    assign accept       = counts.valid && counts.ready;

    wpdr_delta #(.COUNT_BITS(COUNT_BITS)) u_delta_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (dctl),
        .cur     (counts.left_count),
        .dir     (counts.direction),
        .modulus (modulus_reg),
        .delta   (delta_l)
    );

    wpdr_delta #(.COUNT_BITS(COUNT_BITS)) u_delta_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (dctl),
        .cur     (counts.right_count),
        .dir     (counts.direction),
        .modulus (modulus_reg),
        .delta   (delta_r)
    );

    wpdr_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    wpdr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (mid_reg),
        .done    (cordic_done),
        .cos_q20 (cos_q20),
        .sin_q20 (sin_q20)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
            dpp_reg     <= '0;
            yaw_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODULUS: modulus_reg <= cfg.data[MOD_W-1:0];
                REG_DIST:    dpp_reg     <= cfg.data[DPP_W-1:0];
                REG_YAW:     yaw_reg     <= cfg.data[YAW_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            heading_reg   <= heading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg         <= mid_next;
        dl_reg          <= dl_next;
        dr_reg          <= dr_next;
        dist_reg        <= dist_next;
        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_heading_reg <= out_heading_next;
        out_dl_reg      <= out_dl_next;
        out_dr_reg      <= out_dr_next;
    end

    // sequencer: picks the multiplier operands and steps through the request
    always_comb
    begin
        state_next   = state_reg;
        mul_a        = '0;
        mul_b        = '0;
        cordic_start = 1'b0;
        out_load     = 1'b0;
        dctl         = '0;

        dsum  = dsum_t'(dl_reg) + dsum_t'(dr_reg);
        ddiff = dsum_t'(dr_reg) - dsum_t'(dl_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (counts.operation == OP_SET_POSE)
                    begin
                        dctl.clear = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dctl.step  = 1'b1;
                        state_next = S_TURN;
                    end
                end
            end
            S_TURN:
            begin
                mul_a      = {{(MUL_A_W-YAW_W){1'b0}}, yaw_reg};
                mul_b      = {{(MUL_B_W-DSUM_W){ddiff[DSUM_W-1]}}, ddiff};
                state_next = S_DIST;
            end
            S_DIST:
            begin
                mul_a      = {{(MUL_A_W-DPP_W){1'b0}}, dpp_reg};
                mul_b      = {{(MUL_B_W-DSUM_W){dsum[DSUM_W-1]}}, dsum};
                state_next = S_ANGLE;
            end
            S_ANGLE:
            begin
                cordic_start = 1'b1;
                state_next   = S_ROTATE;
            end
            S_ROTATE:
            begin
                if (cordic_done)
                begin
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                mul_a      = {{(MUL_A_W-DIST_W){dist_reg[DIST_W-1]}}, dist_reg};
                mul_b      = cos_q20;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                mul_a      = {{(MUL_A_W-DIST_W){dist_reg[DIST_W-1]}}, dist_reg};
                mul_b      = sin_q20;
                state_next = S_ADDY;
            end
            S_ADDY:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || pose.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        x_next           = x_reg;
        y_next           = y_reg;
        heading_next     = heading_reg;
        mid_next         = mid_reg;
        dl_next          = dl_reg;
        dr_next          = dr_reg;
        dist_next        = dist_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_heading_next = out_heading_reg;
        out_dl_next      = out_dl_reg;
        out_dr_next      = out_dr_reg;
        out_valid_next   = out_valid_reg && !pose.ready;

        // position step: round the Q2^-45 product back to 2^-16 m
        pos_step = product + POS_ROUND;

        if (accept)
        begin
            if (counts.operation == OP_SET_POSE)
            begin
                x_next       = counts.start_x;
                y_next       = counts.start_y;
                heading_next = counts.start_heading;
                dl_next      = '0;
                dr_next      = '0;
            end
            else
            begin
                dl_next = delta_l;
                dr_next = delta_r;
            end
        end

        if (state_reg == S_DIST)
        begin
            // product holds the turn; mid heading uses half of it, floored
            heading_next = heading_reg + product[ANGLE_W-1:0];
            mid_next     = heading_reg + product[ANGLE_W:1];
        end

        if (state_reg == S_ANGLE)
        begin
            dist_next = product[DIST_W-1:0];
        end

        if (state_reg == S_MULY)
        begin
            x_next = x_reg + pos_t'(pos_step[POS_W+28:29]);
        end

        if (state_reg == S_ADDY)
        begin
            y_next = y_reg + pos_t'(pos_step[POS_W+28:29]);
        end

        if (out_load)
        begin
            out_x_next       = x_reg;
            out_y_next       = y_reg;
            out_heading_next = heading_reg;
            out_dl_next      = dl_reg;
            out_dr_next      = dr_reg;
            out_valid_next   = 1'b1;
        end
    end

    assign pose.valid       = out_valid_reg;
    assign pose.pos_x       = out_x_reg;
    assign pose.pos_y       = out_y_reg;
    assign pose.heading     = out_heading_reg;
    assign pose.left_delta  = out_dl_reg;
    assign pose.right_delta = out_dr_reg;

    a_set_pose_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept && counts.operation == OP_SET_POSE
        |=> heading_reg == $past(counts.start_heading) && x_reg == $past(counts.start_x)
            && y_reg == $past(counts.start_y))
        else $error("set-pose request did not load the pose");

    a_set_pose_zero_delta: assert property (@(posedge clk) disable iff (!rst_n)
        accept && counts.operation == OP_SET_POSE |=> dl_reg == '0 && dr_reg == '0)
        else $error("set-pose request left nonzero deltas");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the finish step");

endmodule
